FILE: hw/rtl/rbs_pkg.sv
// Shared types, constants and helpers for the 2D ray / box slab test.
package rbs_pkg;

  localparam int unsigned QBits = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned NumW = 49;
  localparam int unsigned QuotW = 50;
  localparam int unsigned NumCells = NumW;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_MIN_X = 2'd0,
    REG_BOX_MIN_Y = 2'd1,
    REG_BOX_MAX_X = 2'd2,
    REG_BOX_MAX_Y = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [WordW-1:0] origin_x;
    logic signed [WordW-1:0] origin_y;
    logic signed [WordW-1:0] dir_x;
    logic signed [WordW-1:0] dir_y;
    logic signed [WordW-1:0] t_start;
    logic signed [WordW-1:0] t_end;
  } ray_t;

  typedef struct packed {
    logic                    hit;
    logic signed [WordW-1:0] t_enter;
    logic signed [WordW-1:0] t_exit;
  } result_t;

  // One magnitude divider lane: partial remainder, quotient, divisor, sign.
  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [NumW-1:0]  num;
    logic [WordW-1:0] den;
    logic             neg;
  } div_lane_t;

  // Everything an item carries down the cell row.
  typedef struct packed {
    logic                    valid;
    logic signed [WordW-1:0] origin_x;
    logic signed [WordW-1:0] origin_y;
    logic                    zero_x;
    logic                    zero_y;
    logic signed [WordW-1:0] enter;
    logic signed [WordW-1:0] exit;
    div_lane_t [3:0]         lane;
  } cell_data_t;

  // Clamps a signed wide quotient to the 32-bit range.
  function automatic logic signed [WordW-1:0] sat32(input logic signed [QuotW-1:0] v);
    logic signed [QuotW-1:0] hi_lim;
    logic signed [QuotW-1:0] lo_lim;
    hi_lim = QuotW'(signed'(33'sh0_7FFF_FFFF));
    lo_lim = -hi_lim - QuotW'(1);
    if (v > hi_lim) return {1'b0, {(WordW-1){1'b1}}};
    if (v < lo_lim) return {1'b1, {(WordW-1){1'b0}}};
    return v[WordW-1:0];
  endfunction

endpackage

FILE: hw/rtl/rbs_if.sv
// Valid/ready channel interface carrying one beat of payload.
interface rbs_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ray_box_slab_test_2d_unit.sv
// Top level of the 2D ray / axis-aligned box slab test.
// The block takes one ray beat per clock unless the row is stalled and returns
// one result beat per ray, in order. A ray passes one setup register, a row of
// 49 division cells (one quotient bit each, four slab quotients side by side)
// and the output register, with the clipping logic sitting combinationally in
// front of the output register. The row stalls as a whole only when the output
// register holds an untaken result. The user must write box bounds through the
// configuration port while the block is idle, which the block does not enforce.
module ray_box_slab_test_2d_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rbs_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [rbs_pkg::WordW-1:0]        cfg_data,
  rbs_if.sink                              in_ray,
  rbs_if.source                            out_res
);

  logic signed [rbs_pkg::WordW-1:0] box_min_x, box_min_y, box_max_x, box_max_y;
  rbs_pkg::cell_data_t              chain [rbs_pkg::NumCells+1];
  logic                             adv;
  rbs_pkg::result_t                 res_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_min_y <= '0;
      box_max_x <= '0;
      box_max_y <= '0;
    end else if (cfg_we) begin
      unique case (rbs_pkg::cfg_reg_t'(cfg_index))
        rbs_pkg::REG_BOX_MIN_X: box_min_x <= cfg_data;
        rbs_pkg::REG_BOX_MIN_Y: box_min_y <= cfg_data;
        rbs_pkg::REG_BOX_MAX_X: box_max_x <= cfg_data;
        rbs_pkg::REG_BOX_MAX_Y: box_max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole row moves unless a finished result is waiting at the output.
  assign adv = !out_res.valid || out_res.ready;
  assign in_ray.ready = adv;

  // Setup stage: order the interval, form magnitudes and signs.
  always_ff @(posedge clk) begin
    logic signed [rbs_pkg::WordW:0] diff;
    logic signed [rbs_pkg::WordW-1:0] bnd, pos, dv;
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0].valid    <= in_ray.valid;
      chain[0].origin_x <= in_ray.data.origin_x;
      chain[0].origin_y <= in_ray.data.origin_y;
      chain[0].zero_x   <= in_ray.data.dir_x == '0;
      chain[0].zero_y   <= in_ray.data.dir_y == '0;
      if (in_ray.data.t_start > in_ray.data.t_end) begin
        chain[0].enter <= in_ray.data.t_end;
        chain[0].exit  <= in_ray.data.t_start;
      end else begin
        chain[0].enter <= in_ray.data.t_start;
        chain[0].exit  <= in_ray.data.t_end;
      end
      // Lanes: 0 min x, 1 max x, 2 min y, 3 max y.
      for (int i = 0; i < 4; i++) begin
        bnd = (i == 0) ? box_min_x : (i == 1) ? box_max_x : (i == 2) ? box_min_y : box_max_y;
        pos = (i < 2) ? in_ray.data.origin_x : in_ray.data.origin_y;
        dv  = (i < 2) ? in_ray.data.dir_x : in_ray.data.dir_y;
        diff = (rbs_pkg::WordW+1)'(bnd) - (rbs_pkg::WordW+1)'(pos);
        chain[0].lane[i].rem <= '0;
        chain[0].lane[i].num <= {(diff[rbs_pkg::WordW] && diff[rbs_pkg::WordW-1:0] == '0),
                                 (diff[rbs_pkg::WordW] ? rbs_pkg::WordW'(-diff)
                                  : diff[rbs_pkg::WordW-1:0]),
                                 rbs_pkg::QBits'(0)};
        chain[0].lane[i].den <= dv[rbs_pkg::WordW-1] ? rbs_pkg::WordW'(-dv) : dv;
        chain[0].lane[i].neg <= diff[rbs_pkg::WordW] ^ dv[rbs_pkg::WordW-1];
      end
    end
  end

  // Row of division cells.
  for (genvar c = 0; c < rbs_pkg::NumCells; c++) begin : g_cell
    rbs_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (adv),
      .d_in (chain[c]),
      .d_out(chain[c+1])
    );
  end

  // Clipping stage: sign the quotients, saturate, and clip both axes.
  always_comb begin
    logic signed [rbs_pkg::WordW-1:0] t [4];
    logic signed [rbs_pkg::WordW-1:0] a, b, en_v, ex_v;
    logic signed [rbs_pkg::QuotW-1:0] q;
    logic hit_v;
    rbs_pkg::cell_data_t e;
    e = chain[rbs_pkg::NumCells];
    a = '0;
    b = '0;
    for (int i = 0; i < 4; i++) begin
      q = {1'b0, e.lane[i].num};
      if (e.lane[i].neg) q = -q;
      t[i] = rbs_pkg::sat32(q);
    end
    en_v = e.enter;
    ex_v = e.exit;
    hit_v = 1'b1;
    if (e.zero_x) begin
      hit_v = !(e.origin_x < box_min_x || e.origin_x > box_max_x);
    end else begin
      a = (t[0] < t[1]) ? t[0] : t[1];
      b = (t[0] < t[1]) ? t[1] : t[0];
      if (a > en_v) en_v = a;
      if (b < ex_v) ex_v = b;
      hit_v = en_v <= ex_v;
    end
    if (hit_v) begin
      if (e.zero_y) begin
        hit_v = !(e.origin_y < box_min_y || e.origin_y > box_max_y);
      end else begin
        a = (t[2] < t[3]) ? t[2] : t[3];
        b = (t[2] < t[3]) ? t[3] : t[2];
        if (a > en_v) en_v = a;
        if (b < ex_v) ex_v = b;
        hit_v = en_v <= ex_v;
      end
    end
    if (hit_v) hit_v = en_v <= ex_v;
    res_next.hit     = hit_v;
    res_next.t_enter = hit_v ? en_v : '0;
    res_next.t_exit  = hit_v ? ex_v : '0;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_res.valid <= 1'b0;
    end else if (adv) begin
      out_res.valid <= chain[rbs_pkg::NumCells].valid;
      out_res.data  <= res_next;
    end
  end

endmodule

FILE: hw/rtl/rbs_cell.sv
// One restoring division step for all four slab quotients of an item.
module rbs_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  rbs_pkg::cell_data_t d_in,
  output rbs_pkg::cell_data_t d_out
);

  rbs_pkg::cell_data_t d_next;

  // Shift in the next numerator bit and subtract the divisor when it fits.
  always_comb begin
    logic [rbs_pkg::NumW:0] trial;
    d_next = d_in;
    for (int i = 0; i < 4; i++) begin
      trial = {d_in.lane[i].rem, d_in.lane[i].num[rbs_pkg::NumW-1]};
      d_next.lane[i].num = {d_in.lane[i].num[rbs_pkg::NumW-2:0], 1'b0};
      if (trial >= {{(rbs_pkg::NumW-rbs_pkg::WordW+1){1'b0}}, d_in.lane[i].den}) begin
        trial = trial - {{(rbs_pkg::NumW-rbs_pkg::WordW+1){1'b0}}, d_in.lane[i].den};
        d_next.lane[i].num[0] = 1'b1;
      end
      d_next.lane[i].rem = trial[rbs_pkg::NumW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out <= d_next;
    end
  end

endmodule

FILE: verif/tb_ray_box_slab_test_2d_unit.sv
// Self-checking testbench for the 2D ray / axis-aligned box slab test unit.
`timescale 1ns / 1ps

module tb_ray_box_slab_test_2d_unit;

  localparam int ClkHalf = 4;
  localparam int DrainCycles = 64;
  localparam longint SMax = 64'sd2147483647;
  localparam longint SMin = -64'sd2147483648;
  localparam logic signed [31:0] QOne = 32'sh0001_0000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [rbs_pkg::CfgIdxW-1:0] cfg_index;
  logic [rbs_pkg::WordW-1:0] cfg_data;

  rbs_if #(.T(rbs_pkg::ray_t)) ray_ch (clk);
  rbs_if #(.T(rbs_pkg::result_t)) res_ch (clk);

  ray_box_slab_test_2d_unit u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ray(ray_ch.sink),
    .out_res(res_ch.source)
  );

  // Directed stimulus row; a typed expectation overrides the predictor.
  typedef struct {
    rbs_pkg::ray_t    ray;
    bit               typed;
    rbs_pkg::result_t res;
  } ray_row_t;

  longint box_lo_x, box_lo_y, box_hi_x, box_hi_y;
  rbs_pkg::result_t pending_hits[$];
  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  bit row_typed;
  rbs_pkg::result_t row_res;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  // Slab parameter (bound - pos) / dir in Q16.16, saturated to 32 bits.
  function automatic longint slab_param(longint bound, longint pos, longint d);
    longint q;
    q = ((bound - pos) * 65536) / d;
    if (q > SMax) return SMax;
    if (q < SMin) return SMin;
    return q;
  endfunction

  // Clips [enter, exit] against one axis; returns 0 on a miss.
  function automatic bit clip_slab(input longint pos, input longint d, input longint lo,
                                   input longint hi, inout longint enter, inout longint exit);
    longint t1, t2, a, b;
    if (d == 0) return !(pos < lo || pos > hi);
    t1 = slab_param(lo, pos, d);
    t2 = slab_param(hi, pos, d);
    a = (t1 < t2) ? t1 : t2;
    b = (t1 < t2) ? t2 : t1;
    if (a > enter) enter = a;
    if (b < exit) exit = b;
    return enter <= exit;
  endfunction

  function automatic rbs_pkg::result_t predict_hit(rbs_pkg::ray_t r);
    longint enter, exit, tmp;
    bit ok;
    rbs_pkg::result_t res;
    enter = r.t_start;
    exit = r.t_end;
    if (enter > exit) begin
      tmp = enter;
      enter = exit;
      exit = tmp;
    end
    ok = clip_slab(r.origin_x, r.dir_x, box_lo_x, box_hi_x, enter, exit);
    if (ok) ok = clip_slab(r.origin_y, r.dir_y, box_lo_y, box_hi_y, enter, exit);
    res = '0;
    if (ok) begin
      res.hit = 1'b1;
      res.t_enter = enter[31:0];
      res.t_exit = exit[31:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Record the expected result of each accepted ray beat.
  always @(posedge clk) begin
    if (!rst && ray_ch.valid && ray_ch.ready)
      pending_hits.push_back(row_typed ? row_res : predict_hit(ray_ch.data));
  end

  // Compare each result beat against the oldest expectation.
  always @(posedge clk) begin
    rbs_pkg::result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = pending_hits.pop_front();
        if (res_ch.data.hit !== want.hit)
          report_mismatch("hit", res_ch.data.hit, want.hit);
        if (res_ch.data.t_enter !== want.t_enter)
          report_mismatch("t_enter", res_ch.data.t_enter, want.t_enter);
        if (res_ch.data.t_exit !== want.t_exit)
          report_mismatch("t_exit", res_ch.data.t_exit, want.t_exit);
      end
    end
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    res_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(rbs_pkg::cfg_reg_t idx, logic signed [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      rbs_pkg::REG_BOX_MIN_X: box_lo_x = val;
      rbs_pkg::REG_BOX_MIN_Y: box_lo_y = val;
      rbs_pkg::REG_BOX_MAX_X: box_hi_x = val;
      default:                box_hi_y = val;
    endcase
  endtask

  // Let the pipeline empty before touching the box registers.
  task automatic drain();
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_box(logic signed [31:0] lx, logic signed [31:0] ly,
                         logic signed [31:0] hx, logic signed [31:0] hy);
    drain();
    write_reg(rbs_pkg::REG_BOX_MIN_X, lx);
    write_reg(rbs_pkg::REG_BOX_MIN_Y, ly);
    write_reg(rbs_pkg::REG_BOX_MAX_X, hx);
    write_reg(rbs_pkg::REG_BOX_MAX_Y, hy);
  endtask

  // Present one ray beat and hold it until it is taken.
  task automatic send_ray(rbs_pkg::ray_t r, bit typed, rbs_pkg::result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      ray_ch.valid = 1'b0;
      @(negedge clk);
    end
    ray_ch.valid = 1'b1;
    ray_ch.data = r;
    row_typed = typed;
    row_res = res;
    forever begin
      @(posedge clk);
      if (ray_ch.ready) break;
    end
    @(negedge clk);
    ray_ch.valid = 1'b0;
    row_typed = 1'b0;
  endtask

  // Coordinate mix: near the box, full range, small values, or an extreme value.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0, 1, 2: return 32'(int'($urandom_range(40 << 16)) - (20 << 16));
      3:       return $urandom();
      4:       return 32'(int'($urandom_range(8)) - 4);
      default: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [31:0] rand_dir();
    if ($urandom_range(7) == 0) return '0;
    return rand_coord();
  endfunction

  function automatic rbs_pkg::ray_t rand_ray();
    rbs_pkg::ray_t r;
    r.origin_x = rand_coord();
    r.origin_y = rand_coord();
    r.dir_x = rand_dir();
    r.dir_y = rand_dir();
    if ($urandom_range(2) == 0) begin
      r.t_start = 32'h8000_0000;
      r.t_end = 32'h7FFF_FFFF;
    end else begin
      r.t_start = rand_coord();
      r.t_end = rand_coord();
    end
    return r;
  endfunction

  function automatic rbs_pkg::ray_t mk_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                                           logic signed [31:0] dx, logic signed [31:0] dy,
                                           logic signed [31:0] ts, logic signed [31:0] te);
    rbs_pkg::ray_t r;
    r.origin_x = ox;
    r.origin_y = oy;
    r.dir_x = dx;
    r.dir_y = dy;
    r.t_start = ts;
    r.t_end = te;
    return r;
  endfunction

  function automatic rbs_pkg::result_t mk_res(logic h, logic signed [31:0] te,
                                              logic signed [31:0] tx);
    rbs_pkg::result_t r;
    r.hit = h;
    r.t_enter = te;
    r.t_exit = tx;
    return r;
  endfunction

  localparam logic signed [31:0] PMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PMin = 32'sh8000_0000;

  // Main sequence: directed rows, then random phases over several boxes.
  initial begin
    ray_row_t rows[$];
    ray_row_t row;
    rbs_pkg::result_t none;
    int n;
    errors = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = rbs_pkg::REG_BOX_MIN_X;
    cfg_data = '0;
    ray_ch.valid = 1'b0;
    ray_ch.data = '0;
    res_ch.ready = 1'b0;
    row_typed = 1'b0;
    row_res = '0;
    none = '0;
    send_idle_pct = 6;
    recv_idle_pct = 56;
    box_lo_x = 0; box_lo_y = 0; box_hi_x = 0; box_hi_y = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Reset box is the single point at the origin.
    row.typed = 1'b1;
    row.ray = mk_ray(0, 0, 0, 0, PMin, PMax); row.res = mk_res(1, PMin, PMax);
    rows.push_back(row);
    row.ray = mk_ray(0, 0, 0, 0, 5, -3); row.res = mk_res(1, -3, 5);
    rows.push_back(row);
    row.ray = mk_ray(1, 0, 0, 0, PMin, PMax); row.res = mk_res(0, 0, 0);
    rows.push_back(row);
    row.ray = mk_ray(0, -1, 0, 0, PMin, PMax); row.res = mk_res(0, 0, 0);
    rows.push_back(row);
    row.ray = mk_ray(0, 0, QOne, 0, PMin, PMax); row.res = mk_res(1, 0, 0);
    rows.push_back(row);
    row.ray = mk_ray(0, 0, QOne, 0, 1, PMax); row.res = mk_res(0, 0, 0);
    rows.push_back(row);
    // Saturation of the slab quotient at both ends.
    row.ray = mk_ray(PMax, 0, 1, 0, PMin, PMax); row.res = mk_res(1, PMin, PMin);
    rows.push_back(row);
    row.ray = mk_ray(PMin, 0, 1, 0, PMin, PMax); row.res = mk_res(1, PMax, PMax);
    rows.push_back(row);
    row.ray = mk_ray(PMin, 0, -1, 0, PMin, PMax); row.res = mk_res(1, PMin, PMin);
    rows.push_back(row);
    row.ray = mk_ray(0, PMax, 0, 1, PMin, PMax); row.res = mk_res(1, PMin, PMin);
    rows.push_back(row);
    row.typed = 1'b0;
    row.ray = mk_ray(PMax, PMin, PMin, PMax, PMax, PMin); rows.push_back(row);
    row.ray = mk_ray(PMin, PMax, PMax, PMin, PMin, PMin); rows.push_back(row);
    row.ray = mk_ray(0, 0, PMin, PMin, PMax, PMax); rows.push_back(row);
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].res);

    // An ordinary box with a set of directed rays.
    set_box(-10 << 16, -5 << 16, 10 << 16, 20 << 16);
    rows.delete();
    row.typed = 1'b0;
    row.ray = mk_ray(-20 << 16, 0, QOne, 0, PMin, PMax); rows.push_back(row);
    row.ray = mk_ray(0, -20 << 16, 0, QOne, PMin, PMax); rows.push_back(row);
    row.ray = mk_ray(-20 << 16, -20 << 16, QOne, QOne, 0, 12 << 16); rows.push_back(row);
    row.ray = mk_ray(30 << 16, 0, -QOne, 0, PMin, PMax); rows.push_back(row);
    row.ray = mk_ray(10 << 16, 20 << 16, 0, 0, PMin, PMax); rows.push_back(row);
    row.ray = mk_ray(11 << 16, 0, 0, QOne, PMin, PMax); rows.push_back(row);
    row.ray = mk_ray(0, 0, 3, -7, -QOne, QOne); rows.push_back(row);
    foreach (rows[i]) send_ray(rows[i].ray, 1'b0, none);

    // Random phases; idle pattern follows item count.
    n = 0;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_box(-10 << 16, -5 << 16, 10 << 16, 20 << 16);
        1: set_box(PMin, PMin, PMax, PMax);
        2: set_box(10 << 16, 15 << 16, -10 << 16, -15 << 16);
        3: set_box(-2, -2, 2, 2);
        4: set_box(PMax, PMax, PMin, PMin);
        default: set_box(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      endcase
      for (int k = 0; k < 270; k++) begin
        if (n == 630) begin
          send_idle_pct = 56;
          recv_idle_pct = 6;
        end else if (n == 1260) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        // Hold off once mid-phase until every result has come back.
        if (n == 900) while (pending_hits.size() != 0) @(negedge clk);
        send_ray(rand_ray(), 1'b0, none);
        n++;
      end
    end

    drain();
    if (errors == 0)
      $display("tb_ray_box_slab_test_2d_unit: PASS");
    else
      $display("tb_ray_box_slab_test_2d_unit: FAIL");
    $finish;
  end

  // Run limit.
  initial begin
    #4ms;
    $display("tb_ray_box_slab_test_2d_unit: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_if.sv
hw/rtl/rbs_cell.sv
hw/rtl/ray_box_slab_test_2d_unit.sv
verif/tb_ray_box_slab_test_2d_unit.sv
